FILE: src/idpu_pkg.sv
package idpu_pkg;

    localparam int unsigned NUM_REGS = 31;

    localparam logic [4:0] ZERO_REG = 5'd31;

    // Major opcode group in bits 25:23.
    localparam logic [2:0] OPI_ADDSUB = 3'h2;
    localparam logic [2:0] OPI_MOVW   = 3'h5;

    // Wide move opc codes.
    localparam logic [1:0] OPC_MOVN = 2'h0;
    localparam logic [1:0] OPC_MOVZ = 2'h2;
    localparam logic [1:0] OPC_MOVK = 2'h3;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_HW   = 2'd1;
    localparam logic [1:0] ST_BAD_OPC  = 2'd2;
    localparam logic [1:0] ST_BAD_OPI  = 2'd3;

    // NZCV with N in bit 3 and V in bit 0.
    typedef logic [3:0] t_flags;

    typedef struct packed {
        logic [1:0]  status;
        logic        write_enable;
        logic [4:0]  dest_index;
        logic [63:0] write_value;
        logic        flags_updated;
        t_flags      flags;
    } t_result;

    typedef struct packed {
        logic        reg_we;
        logic [4:0]  reg_idx;
        logic [63:0] reg_data;
        logic        flags_we;
        t_flags      flags;
    } t_wr;

endpackage

FILE: src/immediate_data_processing_unit.sv
// A beat accepted into the input register moves on to the result register, which drives
// the outputs; the move waits while a held result is stalled at the output.
// Throughput: one instruction per cycle while the output is not stalled; execution,
// register write and flag update all complete in the single stage between the input
// register and the result register. Reset (synchronous, active low) empties both
// registers and clears all 31 general registers and the NZCV flags to zero.
module immediate_data_processing_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_instruction,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic        o_write_enable,
    output logic [4:0]  o_dest_index,
    output logic [63:0] o_write_value,
    output logic        o_flags_updated,
    output logic        o_flag_n,
    output logic        o_flag_z,
    output logic        o_flag_c,
    output logic        o_flag_v
);

    // Input register: holds the instruction that is executing this cycle.
    logic        r_in_valid;
    logic [31:0] r_instruction;

    // Result register: holds the finished beat until the consumer takes it.
    logic                r_out_valid;
    idpu_pkg::t_result   r_result;

    logic                advance;
    logic [4:0]          rd_addr;
    logic [63:0]         rd_data;
    idpu_pkg::t_flags    flags;
    idpu_pkg::t_result   n_result;
    idpu_pkg::t_wr       exec_wr;
    idpu_pkg::t_wr       commit_wr;

    // The executing instruction moves to the result register when that register is
    // empty or its beat is being taken this cycle. Architectural state is written at
    // the same edge, so the next instruction always sees up-to-date registers and
    // flags and no forwarding is needed.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    always_comb begin
        commit_wr          = exec_wr;
        commit_wr.reg_we   = exec_wr.reg_we && advance;
        commit_wr.flags_we = exec_wr.flags_we && advance;
    end

    idpu_exec u_exec (
        .i_instruction (r_instruction),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .i_flags       (flags),
        .o_result      (n_result),
        .o_wr          (exec_wr)
    );

    idpu_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .i_wr      (commit_wr),
        .o_rd_data (rd_data),
        .o_flags   (flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; they are qualified by the valid bits.
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_instruction <= i_instruction;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_result.status;
    assign o_write_enable  = r_result.write_enable;
    assign o_dest_index    = r_result.dest_index;
    assign o_write_value   = r_result.write_value;
    assign o_flags_updated = r_result.flags_updated;
    assign o_flag_n        = r_result.flags[3];
    assign o_flag_z        = r_result.flags[2];
    assign o_flag_c        = r_result.flags[1];
    assign o_flag_v        = r_result.flags[0];

    // An illegal encoding never writes a register or the flags.
    a_illegal_no_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_result.status != idpu_pkg::ST_OK))
            |-> (!r_result.write_enable && !r_result.flags_updated))
        else $error("illegal encoding reported a state update");

    // The zero register is never reported as written.
    a_no_zero_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.write_enable) |-> (r_result.dest_index != idpu_pkg::ZERO_REG))
        else $error("write reported to the zero register");

    // The input side only stalls while an instruction is held in the input register.
    a_stall_needs_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with an empty input register");

    // An instruction that moves on always leaves a beat in the result register.
    a_advance_fills : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advanced instruction lost");

endmodule

FILE: src/idpu_regfile.sv
module idpu_regfile (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [4:0]          i_rd_addr,
    input  idpu_pkg::t_wr       i_wr,
    output logic [63:0]         o_rd_data,
    output idpu_pkg::t_flags    o_flags
);

    logic [63:0]      r_mem [idpu_pkg::NUM_REGS];
    idpu_pkg::t_flags r_flags;

    // Index 31 is the zero register and has no storage.
    assign o_rd_data = (i_rd_addr == idpu_pkg::ZERO_REG) ? 64'd0 : r_mem[i_rd_addr];
    assign o_flags   = r_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < idpu_pkg::NUM_REGS; i++) begin
                r_mem[i] <= 64'd0;
            end
            r_flags <= 4'd0;
        end else begin
            if (i_wr.reg_we && (i_wr.reg_idx != idpu_pkg::ZERO_REG)) begin
                r_mem[i_wr.reg_idx] <= i_wr.reg_data;
            end
            if (i_wr.flags_we) begin
                r_flags <= i_wr.flags;
            end
        end
    end

endmodule

FILE: src/idpu_exec.sv
module idpu_exec (
    input  logic [31:0]         i_instruction,
    output logic [4:0]          o_rd_addr,
    input  logic [63:0]         i_rd_data,
    input  idpu_pkg::t_flags    i_flags,
    output idpu_pkg::t_result   o_result,
    output idpu_pkg::t_wr       o_wr
);

    logic        sf;
    logic [1:0]  opc;
    logic [2:0]  opi;
    logic        sh;
    logic [11:0] imm12;
    logic [1:0]  hw;
    logic [15:0] imm16;
    logic [4:0]  rn;
    logic [4:0]  rd;

    assign sf    = i_instruction[31];
    assign opc   = i_instruction[30:29];
    assign opi   = i_instruction[25:23];
    assign sh    = i_instruction[22];
    assign imm12 = i_instruction[21:10];
    assign hw    = i_instruction[22:21];
    assign imm16 = i_instruction[20:5];
    assign rn    = i_instruction[9:5];
    assign rd    = i_instruction[4:0];

    // Add/sub reads rn; only MOVK reads the old value of rd.
    assign o_rd_addr = (opi == idpu_pkg::OPI_ADDSUB) ? rn : rd;

    always_comb begin
        logic [63:0] wmask;
        logic [63:0] lhs;
        logic [63:0] rhs;
        logic [64:0] sum;
        logic [63:0] as_res;
        logic [63:0] vx;
        logic        is_sub;
        logic        fn;
        logic        fz;
        logic        fc;
        logic        fv;
        logic [5:0]  shamt;
        logic [63:0] imm_sh;
        logic [63:0] mv_res;
        logic [1:0]  status;
        logic [63:0] result;
        logic        set_flags;

        wmask  = sf ? {64{1'b1}} : {32'd0, {32{1'b1}}};
        is_sub = opc[1];
        lhs    = i_rd_data & wmask;
        rhs    = sh ? {40'd0, imm12, 12'd0} : {52'd0, imm12};
        sum    = is_sub ? ({1'b0, lhs} - {1'b0, rhs}) : ({1'b0, lhs} + {1'b0, rhs});
        as_res = sum[63:0] & wmask;

        vx = is_sub ? ((lhs ^ rhs) & (lhs ^ as_res)) : (~(lhs ^ rhs) & (lhs ^ as_res));
        fn = sf ? as_res[63] : as_res[31];
        fz = (as_res == 64'd0);
        fc = is_sub ? (lhs >= rhs) : (as_res < lhs);
        fv = sf ? vx[63] : vx[31];

        shamt  = {hw, 4'd0};
        imm_sh = {48'd0, imm16} << shamt;

        status    = idpu_pkg::ST_OK;
        mv_res    = 64'd0;
        result    = 64'd0;
        set_flags = 1'b0;

        if (opi == idpu_pkg::OPI_ADDSUB) begin
            result    = as_res;
            set_flags = opc[0];
        end else if (opi == idpu_pkg::OPI_MOVW) begin
            if (!sf && hw[1]) begin
                status = idpu_pkg::ST_BAD_HW;
            end else begin
                case (opc)
                    idpu_pkg::OPC_MOVN: mv_res = ~imm_sh;
                    idpu_pkg::OPC_MOVZ: mv_res = imm_sh;
                    idpu_pkg::OPC_MOVK: begin
                        mv_res = (i_rd_data & ~({48'd0, 16'hFFFF} << shamt)) | imm_sh;
                    end
                    default: status = idpu_pkg::ST_BAD_OPC;
                endcase
            end
            result = mv_res & wmask;
        end else begin
            status = idpu_pkg::ST_BAD_OPI;
        end

        if (status != idpu_pkg::ST_OK) begin
            result = 64'd0;
        end

        o_result.status        = status;
        o_result.write_enable  = (status == idpu_pkg::ST_OK) && (rd != idpu_pkg::ZERO_REG);
        o_result.dest_index    = (status == idpu_pkg::ST_OK) ? rd : 5'd0;
        o_result.write_value   = result;
        o_result.flags_updated = set_flags;
        o_result.flags         = set_flags ? {fn, fz, fc, fv} : i_flags;

        o_wr.reg_we   = o_result.write_enable;
        o_wr.reg_idx  = rd;
        o_wr.reg_data = result;
        o_wr.flags_we = set_flags;
        o_wr.flags    = {fn, fz, fc, fv};
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // Arithmetic forms of the add/sub immediate group. Bit 1 selects subtraction and
    // bit 0 selects the flag-setting variant.
    typedef enum logic [1:0] {
        OP_ADD  = 2'h0,
        OP_ADDS = 2'h1,
        OP_SUB  = 2'h2,
        OP_SUBS = 2'h3
    } t_arith_op;

    // The one wide move opc value that the block must reject.
    localparam logic [1:0] OPC_MOVW_BAD = 2'h1;

    // Cycles the receiver holds off during the back-pressure phase.
    localparam int LONG_HOLD = 50;

    // One instruction in flight together with the result it must produce.
    typedef struct {
        logic [31:0]       word;
        idpu_pkg::t_result outcome;
    } t_expectation;

    // Architectural model of the execute stage plus the queue of results that the
    // block still owes us, oldest first.
    class exec_scoreboard;
        logic [63:0]      gpr [idpu_pkg::NUM_REGS];
        idpu_pkg::t_flags nzcv;
        t_expectation     pending_results [$];
        int               fail_count;
        int               checked_count;
        int               arith_count;
        int               move_count;
        int               rejected_count;

        function new();
            foreach (gpr[i]) gpr[i] = '0;
            nzcv = '0;
            fail_count = 0;
            checked_count = 0;
            arith_count = 0;
            move_count = 0;
            rejected_count = 0;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        // Executes one instruction on the model state and returns its result beat.
        function idpu_pkg::t_result execute_word(logic [31:0] ins);
            idpu_pkg::t_result r;
            logic        sf;
            logic [1:0]  opc;
            logic [2:0]  opi;
            logic [4:0]  rd;
            logic [1:0]  hw;
            logic [63:0] wmask, lhs, rhs, res, old, imm16, ovf;
            int unsigned top, shift;

            sf = ins[31];
            opc = ins[30:29];
            opi = ins[25:23];
            rd = ins[4:0];
            wmask = sf ? {64{1'b1}} : 64'h0000_0000_FFFF_FFFF;
            top = sf ? 63 : 31;
            res = '0;
            r = '0;
            r.status = idpu_pkg::ST_OK;

            if (opi == idpu_pkg::OPI_ADDSUB) begin
                lhs = (ins[9:5] == idpu_pkg::ZERO_REG) ? 64'd0 : gpr[ins[9:5]];
                lhs &= wmask;
                rhs = ins[22] ? {40'd0, ins[21:10], 12'd0} : {52'd0, ins[21:10]};
                rhs &= wmask;
                res = (opc[1] ? lhs - rhs : lhs + rhs) & wmask;
                if (opc[0]) begin
                    if (opc[1]) begin
                        ovf = (lhs ^ rhs) & (lhs ^ res);
                        nzcv[1] = (lhs >= rhs);
                    end else begin
                        ovf = ~(lhs ^ rhs) & (lhs ^ res);
                        nzcv[1] = (res < lhs);
                    end
                    nzcv[3] = res[top];
                    nzcv[2] = (res == 64'd0);
                    nzcv[0] = ovf[top];
                    r.flags_updated = 1'b1;
                end
            end else if (opi == idpu_pkg::OPI_MOVW) begin
                hw = ins[22:21];
                imm16 = {48'd0, ins[20:5]};
                shift = hw * 16;
                if (!sf && hw > 2'd1) begin
                    r.status = idpu_pkg::ST_BAD_HW;
                end else begin
                    case (opc)
                        idpu_pkg::OPC_MOVN: res = ~(imm16 << shift);
                        idpu_pkg::OPC_MOVZ: res = imm16 << shift;
                        idpu_pkg::OPC_MOVK: begin
                            old = (rd == idpu_pkg::ZERO_REG) ? 64'd0 : gpr[rd];
                            res = (old & ~(64'hFFFF << shift)) | (imm16 << shift);
                        end
                        default: r.status = idpu_pkg::ST_BAD_OPC;
                    endcase
                end
                res &= wmask;
            end else begin
                r.status = idpu_pkg::ST_BAD_OPI;
            end

            if (r.status != idpu_pkg::ST_OK) begin
                res = '0;
                rd = '0;
            end else if (rd != idpu_pkg::ZERO_REG) begin
                gpr[rd] = res;
            end

            r.write_enable = (r.status == idpu_pkg::ST_OK) && (rd != idpu_pkg::ZERO_REG);
            r.dest_index = rd;
            r.write_value = res;
            r.flags = nzcv;
            return r;
        endfunction

        // Called for every instruction beat the block accepts.
        function void note_instruction(logic [31:0] word);
            t_expectation e;
            e.word = word;
            e.outcome = execute_word(word);
            pending_results.push_back(e);
            if (e.outcome.status != idpu_pkg::ST_OK) rejected_count++;
            else if (word[25:23] == idpu_pkg::OPI_ADDSUB) arith_count++;
            else move_count++;
        endfunction

        function void check_field(logic [31:0] word, string name, logic [63:0] exp_val,
                                  logic [63:0] act_val);
            if (act_val !== exp_val) begin
                $display("%0t ns: instruction %h, %s expected %h actual %h",
                         $time, word, name, exp_val, act_val);
                fail_count++;
            end
        endfunction

        // Called for every result beat the block hands over.
        function void check_result(idpu_pkg::t_result got);
            t_expectation e;
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual status %0d value %h",
                         $time, got.status, got.write_value);
                fail_count++;
                return;
            end
            e = pending_results.pop_front();
            checked_count++;
            check_field(e.word, "status", 64'(e.outcome.status), 64'(got.status));
            check_field(e.word, "write_enable", 64'(e.outcome.write_enable),
                        64'(got.write_enable));
            check_field(e.word, "dest_index", 64'(e.outcome.dest_index), 64'(got.dest_index));
            check_field(e.word, "write_value", e.outcome.write_value, got.write_value);
            check_field(e.word, "flags_updated", 64'(e.outcome.flags_updated),
                        64'(got.flags_updated));
            check_field(e.word, "flag_n", 64'(e.outcome.flags[3]), 64'(got.flags[3]));
            check_field(e.word, "flag_z", 64'(e.outcome.flags[2]), 64'(got.flags[2]));
            check_field(e.word, "flag_c", 64'(e.outcome.flags[1]), 64'(got.flags[1]));
            check_field(e.word, "flag_v", 64'(e.outcome.flags[0]), 64'(got.flags[0]));
        endfunction
    endclass

    // All block inputs start at known values at time zero.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [31:0] i_instruction = '0;
    logic        i_out_stall = 1'b0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic        o_write_enable;
    logic [4:0]  o_dest_index;
    logic [63:0] o_write_value;
    logic        o_flags_updated;
    logic        o_flag_n;
    logic        o_flag_z;
    logic        o_flag_c;
    logic        o_flag_v;

    exec_scoreboard board = new();

    // Idling controls. The sender and receiver each draw a wait of 0 to the
    // current maximum per beat; a maximum of zero gives a stretch at full rate.
    int unsigned tx_gap_max = 4;
    int unsigned rx_wait_max = 4;
    int unsigned rx_wait = 0;
    bit          hold_request = 1'b0;

    immediate_data_processing_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_instruction  (i_instruction),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_write_enable (o_write_enable),
        .o_dest_index   (o_dest_index),
        .o_write_value  (o_write_value),
        .o_flags_updated(o_flags_updated),
        .o_flag_n       (o_flag_n),
        .o_flag_z       (o_flag_z),
        .o_flag_c       (o_flag_c),
        .o_flag_v       (o_flag_v)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Safety net: 2 ms is ample for the slowest legal run.
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: drives the output stall at falling edges. A long hold-off is counted
    // here, in its own process, so the sender keeps offering beats meanwhile.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (rx_wait > 0) begin
                i_out_stall <= 1'b1;
                rx_wait--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Result monitor: samples at the rising edge, where a beat moves when valid is
    // high and stall is low. Each accepted beat draws the receiver's next wait.
    always @(posedge i_clk) begin
        idpu_pkg::t_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.status = o_status;
            got.write_enable = o_write_enable;
            got.dest_index = o_dest_index;
            got.write_value = o_write_value;
            got.flags_updated = o_flags_updated;
            got.flags = {o_flag_n, o_flag_z, o_flag_c, o_flag_v};
            board.check_result(got);
            rx_wait = $urandom_range(0, rx_wait_max);
        end
    end

    // Sends one instruction beat. The valid line is only lowered when a gap is drawn,
    // so back-to-back beats never see it dropped and raised in the same step.
    task automatic issue_instruction(input logic [31:0] word);
        int unsigned gap;
        gap = $urandom_range(0, tx_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_instruction <= word;
        do @(posedge i_clk); while (o_in_stall);
        board.note_instruction(word);
    endtask

    task automatic wait_for_drain();
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    // Encoders. Bits 28:26 are not decoded by the block, so they carry random fill.
    function automatic logic [31:0] arith_word(bit sf, t_arith_op op, bit sh,
                                               logic [11:0] imm12, logic [4:0] rn,
                                               logic [4:0] rd);
        logic [2:0] fill;
        fill = 3'($urandom);
        return {sf, op, fill, idpu_pkg::OPI_ADDSUB, sh, imm12, rn, rd};
    endfunction

    function automatic logic [31:0] move_word(bit sf, logic [1:0] opc, logic [1:0] hw,
                                              logic [15:0] imm16, logic [4:0] rd);
        logic [2:0] fill;
        fill = 3'($urandom);
        return {sf, opc, fill, idpu_pkg::OPI_MOVW, hw, imm16, rd};
    endfunction

    function automatic logic [31:0] bad_opi_word();
        logic [31:0] word;
        logic [2:0]  opi;
        word = $urandom;
        do opi = 3'($urandom);
        while (opi == idpu_pkg::OPI_ADDSUB || opi == idpu_pkg::OPI_MOVW);
        word[25:23] = opi;
        return word;
    endfunction

    // Immediates lean toward the edges where carries and overflows live.
    function automatic logic [11:0] pick_imm12();
        case ($urandom_range(0, 5))
            0: return 12'h000;
            1: return 12'hFFF;
            2: return 12'h001;
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_imm16();
        case ($urandom_range(0, 6))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly legal add/sub and wide moves so the register file builds up real values,
    // with raw noise words and deliberately broken encodings mixed in.
    function automatic logic [31:0] random_instruction();
        int unsigned pick;
        bit          sf;
        logic [1:0]  opc;
        logic [1:0]  hw;
        pick = $urandom_range(0, 99);
        sf = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 2))
            0: opc = idpu_pkg::OPC_MOVN;
            1: opc = idpu_pkg::OPC_MOVZ;
            default: opc = idpu_pkg::OPC_MOVK;
        endcase
        hw = sf ? 2'($urandom_range(0, 3)) : 2'($urandom_range(0, 1));
        if (pick < 40) begin
            return arith_word(sf, t_arith_op'($urandom_range(0, 3)),
                              1'($urandom_range(0, 1)), pick_imm12(),
                              5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
        end else if (pick < 75) begin
            return move_word(sf, opc, hw, pick_imm16(), 5'($urandom_range(0, 31)));
        end else if (pick < 90) begin
            return $urandom;
        end else if (pick < 94) begin
            return move_word(1'b0, 2'($urandom), 2'($urandom_range(2, 3)), pick_imm16(),
                             5'($urandom_range(0, 31)));
        end else if (pick < 97) begin
            return move_word(sf, OPC_MOVW_BAD, hw, pick_imm16(), 5'($urandom_range(0, 31)));
        end
        return bad_opi_word();
    endfunction

    // Directed opening: edge values, every operation, the zero register on both sides,
    // and each illegal encoding, including the hw check winning over the bad opc.
    task automatic run_directed();
        issue_instruction(move_word(1'b1, idpu_pkg::OPC_MOVZ, 2'd3, 16'hFFFF, 5'd1));
        issue_instruction(move_word(1'b1, idpu_pkg::OPC_MOVK, 2'd0, 16'h0001, 5'd1));
        issue_instruction(move_word(1'b1, idpu_pkg::OPC_MOVN, 2'd0, 16'h0000, 5'd2));
        issue_instruction(move_word(1'b0, idpu_pkg::OPC_MOVN, 2'd1, 16'h0000, 5'd3));
        // Carry out with a zero result in both widths.
        issue_instruction(arith_word(1'b1, OP_ADDS, 1'b0, 12'h001, 5'd2, 5'd4));
        issue_instruction(arith_word(1'b0, OP_ADDS, 1'b0, 12'h001, 5'd3, 5'd5));
        // Subtraction with and without a borrow.
        issue_instruction(arith_word(1'b1, OP_SUBS, 1'b0, 12'h000, 5'd0, 5'd6));
        issue_instruction(arith_word(1'b1, OP_SUBS, 1'b0, 12'h001, 5'd0, 5'd6));
        // Build the largest positive 64-bit value and overflow it.
        issue_instruction(move_word(1'b1, idpu_pkg::OPC_MOVZ, 2'd3, 16'h7FFF, 5'd7));
        issue_instruction(move_word(1'b1, idpu_pkg::OPC_MOVK, 2'd2, 16'hFFFF, 5'd7));
        issue_instruction(move_word(1'b1, idpu_pkg::OPC_MOVK, 2'd1, 16'hFFFF, 5'd7));
        issue_instruction(move_word(1'b1, idpu_pkg::OPC_MOVK, 2'd0, 16'hFFFF, 5'd7));
        issue_instruction(arith_word(1'b1, OP_ADDS, 1'b0, 12'h001, 5'd7, 5'd8));
        // Most negative value minus one overflows the other way.
        issue_instruction(move_word(1'b1, idpu_pkg::OPC_MOVZ, 2'd3, 16'h8000, 5'd9));
        issue_instruction(arith_word(1'b1, OP_SUBS, 1'b0, 12'h001, 5'd9, 5'd10));
        // 32-bit overflow with the shifted immediate.
        issue_instruction(move_word(1'b0, idpu_pkg::OPC_MOVZ, 2'd1, 16'h7FFF, 5'd11));
        issue_instruction(move_word(1'b0, idpu_pkg::OPC_MOVK, 2'd0, 16'hFFFF, 5'd11));
        issue_instruction(arith_word(1'b0, OP_ADDS, 1'b1, 12'hFFF, 5'd11, 5'd12));
        // Non-flag forms, a zero-register source, and zero-register destinations.
        issue_instruction(arith_word(1'b1, OP_ADD, 1'b1, 12'hFFF, 5'd1, 5'd13));
        issue_instruction(arith_word(1'b0, OP_SUB, 1'b0, 12'hFFF, idpu_pkg::ZERO_REG,
                                     5'd14));
        issue_instruction(arith_word(1'b1, OP_SUBS, 1'b1, 12'hFFF, 5'd2,
                                     idpu_pkg::ZERO_REG));
        issue_instruction(move_word(1'b1, idpu_pkg::OPC_MOVK, 2'd2, 16'hABCD,
                                    idpu_pkg::ZERO_REG));
        // Illegal encodings.
        issue_instruction(move_word(1'b0, idpu_pkg::OPC_MOVZ, 2'd2, 16'h1234, 5'd15));
        issue_instruction(move_word(1'b0, OPC_MOVW_BAD, 2'd3, 16'hFFFF, 5'd16));
        issue_instruction(move_word(1'b1, OPC_MOVW_BAD, 2'd0, 16'hFFFF, 5'd16));
        issue_instruction(bad_opi_word());
    endtask

    initial begin
        // Hold reset from time zero, then release it at a falling edge.
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        for (int i = 0; i < 950; i++) begin
            if (i == 300) begin
                // Back-pressure: the receiver stalls for a long stretch while the
                // sender keeps offering beats at full rate, filling the pipeline.
                hold_request = 1'b1;
                tx_gap_max = 0;
            end else if (i == 340) begin
                // A stretch with no idling on either side.
                rx_wait_max = 0;
            end else if (i == 490) begin
                // The sender pauses until every outstanding result has come back.
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                wait_for_drain();
                tx_gap_max = 4;
                rx_wait_max = 4;
            end
            issue_instruction(random_instruction());
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Let the two-stage pipeline settle after the last expected beat.
        wait_for_drain();
        repeat (8) @(posedge i_clk);

        $display("Checked %0d results: %0d add/sub, %0d wide moves, %0d rejected encodings,",
                 board.checked_count, board.arith_count, board.move_count,
                 board.rejected_count);
        $display("including a %0d-cycle output hold-off and a full drain mid-run.", LONG_HOLD);
        if (board.fail_count == 0 && board.outstanding() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: immediate_data_processing_unit.f
src/idpu_pkg.sv
src/idpu_regfile.sv
src/idpu_exec.sv
src/immediate_data_processing_unit.sv
verif/tb_top.sv
